// ===== src/gaze_frame_unpack_offset_tracker_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef GAZE_FRAME_UNPACK_OFFSET_TRACKER_CORE_ASSERT_SVH
`define GAZE_FRAME_UNPACK_OFFSET_TRACKER_CORE_ASSERT_SVH

// Check a property outside reset.
`define GFU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("gfu assertion failed");

// Check a property at every edge, reset included.
`define GFU_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("gfu assertion failed");

`endif

// ===== src/gfu_pkg.sv =====
package gfu_pkg;

   localparam int unsigned FRAME_BYTES_DEF = 56;
   localparam int unsigned POS_W           = 6;
   localparam logic [POS_W-1:0] POS_MAX    = 6'd63;

   // Byte positions that carry the two sample pairs
   localparam logic [POS_W-1:0] POS_A_HI  = 6'd3;
   localparam logic [POS_W-1:0] POS_A_MID = 6'd4;
   localparam logic [POS_W-1:0] POS_A_LO  = 6'd5;
   localparam logic [POS_W-1:0] POS_B_HI  = 6'd31;
   localparam logic [POS_W-1:0] POS_B_MID = 6'd32;
   localparam logic [POS_W-1:0] POS_B_LO  = 6'd33;

   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned DELTA_W  = 16;
   localparam int unsigned OUT_W    = 32;

   localparam logic [SAMPLE_W-1:0] WIN_RESET   = 12'd2048;
   localparam logic [SAMPLE_W-1:0] UPPER_RESET = 12'd3939;
   localparam logic [SAMPLE_W-1:0] LOWER_RESET = 12'd256;

   // Power-of-two queue depths
   localparam int unsigned ITEM_DEPTH = 2;
   localparam int unsigned RSP_DEPTH  = 4;

   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER = 1'b1;

   typedef logic [3:0][SAMPLE_W-1:0] win_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] upper;
      logic [SAMPLE_W-1:0] lower;
   } thresh_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] x;
      logic [SAMPLE_W-1:0] y;
      logic                slot;
   } sample_item_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] gaze_x;
      logic signed [OUT_W-1:0] gaze_y;
      logic                    slot;
   } result_item_type;

   // Clamp a 34-bit signed sum into the signed 32-bit range.
   function automatic logic signed [OUT_W-1:0] sat32(input logic signed [OUT_W+1:0] s);
      logic [OUT_W-1:0] res;
      if ((s[OUT_W+1] == s[OUT_W]) && (s[OUT_W] == s[OUT_W-1])) begin
         res = s[OUT_W-1:0];
      end else if (s[OUT_W+1]) begin
         res = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(OUT_W-1){1'b1}}};
      end
      return $signed(res);
   endfunction

   // Signed offset change for a freshly shifted window.
   function automatic logic signed [DELTA_W-1:0] axis_delta(input win_type w,
                                                            input thresh_type thr);
      logic [DELTA_W-1:0] v;
      logic [DELTA_W-1:0] t;
      logic [DELTA_W-1:0] d;
      logic [DELTA_W-1:0] res;
      v = DELTA_W'(w[0]) - DELTA_W'(w[1]) * 16'd3 + DELTA_W'(w[2]) * 16'd3
          - DELTA_W'(w[3]);
      // halve, rounding toward zero
      t = v + {{(DELTA_W-1){1'b0}}, v[DELTA_W-1]};
      d = {t[DELTA_W-1], t[DELTA_W-1:1]};
      if (w[1] > thr.upper) begin
         res = -d;
      end else if (w[1] < thr.lower) begin
         res = d;
      end else begin
         res = '0;
      end
      return $signed(res);
   endfunction

endpackage

// ===== src/gfu_fifo.sv =====
module gfu_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== src/gfu_front.sv =====
module gfu_front #(
   parameter int unsigned FRAME_BYTES = gfu_pkg::FRAME_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_valid,
   input  logic [7:0]               data_byte,
   input  logic                     frame_start,
   output logic                     item_push,
   output gfu_pkg::sample_item_type item
);
   import gfu_pkg::*;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    pos;
   logic [SAMPLE_W-1:0] held_y_ff, held_y_in;
   logic [3:0]          held_nib_ff, held_nib_in;
   logic                in_frame;

   always_comb begin
      pos         = frame_start ? '0 : pos_ff;
      in_frame    = ({1'b0, pos} < (POS_W+1)'(FRAME_BYTES));
      pos_in      = pos_ff;
      held_y_in   = held_y_ff;
      held_nib_in = held_nib_ff;
      item_push   = 1'b0;
      item.x      = {held_nib_ff, data_byte};
      item.y      = held_y_ff;
      item.slot   = (pos == POS_B_LO);
      if (byte_valid) begin
         pos_in = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
         if (in_frame) begin
            if (pos == POS_A_HI || pos == POS_B_HI) begin
               held_y_in = {data_byte, 4'd0};
            end
            if (pos == POS_A_MID || pos == POS_B_MID) begin
               held_y_in   = {held_y_ff[SAMPLE_W-1:4], data_byte[7:4]};
               held_nib_in = data_byte[3:0];
            end
            if (pos == POS_A_LO || pos == POS_B_LO) begin
               item_push = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         held_y_ff   <= '0;
         held_nib_ff <= '0;
      end else begin
         pos_ff      <= pos_in;
         held_y_ff   <= held_y_in;
         held_nib_ff <= held_nib_in;
      end
   end

endmodule

// ===== src/gfu_track.sv =====
module gfu_track (
   input  logic                     clock,
   input  logic                     reset,
   input  gfu_pkg::thresh_type      thresh,
   input  logic                     item_empty,
   input  gfu_pkg::sample_item_type item,
   output logic                     item_pop,
   output gfu_pkg::result_item_type rsp_item,
   output logic                     rsp_empty,
   input  logic                     rsp_pop
);
   import gfu_pkg::*;

   localparam int unsigned CW = $clog2(RSP_DEPTH+1);

   win_type                   x_win_ff, x_win_in;
   win_type                   y_win_ff, y_win_in;
   logic signed [OUT_W-1:0]   x_off_ff, x_off_in;
   logic signed [OUT_W-1:0]   y_off_ff, y_off_in;

   logic                      s1_valid_ff;
   logic signed [DELTA_W-1:0] s1_x_delta_ff, s1_y_delta_ff;
   logic [SAMPLE_W-1:0]       s1_x_w2_ff, s1_y_w2_ff;
   logic                      s1_slot_ff;

   logic                      s2_valid_ff;
   logic signed [OUT_W-1:0]   s2_x_off_ff, s2_y_off_ff;
   logic [SAMPLE_W-1:0]       s2_x_w2_ff, s2_y_w2_ff;
   logic                      s2_slot_ff;

   logic [CW-1:0]             rsp_count;
   logic [CW:0]               used;
   logic                      rsp_full;
   result_item_type           result;

   // Credit check: the result queue must have room for all words in flight
   always_comb begin
      used     = {1'b0, rsp_count} + (CW+1)'(s1_valid_ff) + (CW+1)'(s2_valid_ff);
      item_pop = ~item_empty && (used < (CW+1)'(RSP_DEPTH));
      x_win_in = {item.x, x_win_ff[3:1]};
      y_win_in = {item.y, y_win_ff[3:1]};
   end

   // Offset update, sequential in stage two
   always_comb begin
      x_off_in = sat32(34'(x_off_ff) + 34'(s1_x_delta_ff));
      y_off_in = sat32(34'(y_off_ff) + 34'(s1_y_delta_ff));
   end

   always_comb begin
      result.gaze_x = sat32(34'(s2_x_off_ff) + $signed({22'd0, s2_x_w2_ff}));
      result.gaze_y = sat32(34'(s2_y_off_ff) + $signed({22'd0, s2_y_w2_ff}));
      result.slot   = s2_slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_win_ff    <= {4{WIN_RESET}};
         y_win_ff    <= {4{WIN_RESET}};
         x_off_ff    <= '0;
         y_off_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= item_pop;
         s2_valid_ff <= s1_valid_ff;
         if (item_pop) begin
            x_win_ff <= x_win_in;
            y_win_ff <= y_win_in;
         end
         if (s1_valid_ff) begin
            x_off_ff <= x_off_in;
            y_off_ff <= y_off_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         s1_x_delta_ff <= axis_delta(x_win_in, thresh);
         s1_y_delta_ff <= axis_delta(y_win_in, thresh);
         s1_x_w2_ff    <= x_win_in[2];
         s1_y_w2_ff    <= y_win_in[2];
         s1_slot_ff    <= item.slot;
      end
      if (s1_valid_ff) begin
         s2_x_off_ff <= x_off_in;
         s2_y_off_ff <= y_off_in;
         s2_x_w2_ff  <= s1_x_w2_ff;
         s2_y_w2_ff  <= s1_y_w2_ff;
         s2_slot_ff  <= s1_slot_ff;
      end
   end

   gfu_fifo #(
      .WIDTH($bits(result_item_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (s2_valid_ff),
      .wr_data (result),
      .pop     (rsp_pop),
      .rd_data (rsp_item),
      .full    (rsp_full),
      .empty   (rsp_empty),
      .count   (rsp_count)
   );

   // Credit scheme keeps pushes off a full queue; full stays unobserved
   logic unused_full;
   assign unused_full = rsp_full;

endmodule

// ===== src/gaze_frame_unpack_offset_tracker_core.sv =====
// Path: the byte that completes a sample pair is written to the pair queue, then passes
// the window/delta stage, the offset stage and the result queue on its way to the rsp side.
// Throughput: one byte per cycle unless req_full; the window/offset pipeline takes one pair
// per cycle while the result queue has credit. req_full rises only when the 2-deep pair queue
// backs up behind a stalled result side. Reset (synchronous, active high): windows to 2048,
// offsets and byte count to 0, thresholds to 3939 / 256, both queues emptied.
module gaze_frame_unpack_offset_tracker_core #(
   parameter int unsigned FRAME_BYTES = gfu_pkg::FRAME_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // byte input
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_frame_start,
   // result words
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [gfu_pkg::OUT_W-1:0]     rsp_gaze_x,
   output logic signed [gfu_pkg::OUT_W-1:0]     rsp_gaze_y,
   output logic                                 rsp_sample_slot,
   // threshold registers
   input  logic                                 csr_we,
   input  logic [gfu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gfu_pkg::SAMPLE_W-1:0]         csr_wdata
);
   import gfu_pkg::*;

   thresh_type      thresh_ff, thresh_in;
   logic            byte_take;
   logic            front_push;
   sample_item_type front_item;
   sample_item_type queued_item;
   logic            item_full;
   logic            item_empty;
   logic            item_pop;
   logic [$clog2(ITEM_DEPTH+1)-1:0] item_count;
   result_item_type rsp_item;

   // Take a byte whenever the pair queue has room; most bytes push nothing
   assign req_full  = item_full;
   assign byte_take = req_push & ~item_full;

   // Threshold registers: plain write, no read-back
   always_comb begin
      thresh_in = thresh_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_UPPER: thresh_in.upper = csr_wdata;
            CSR_LOWER: thresh_in.lower = csr_wdata;
            default:   thresh_in = thresh_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.upper <= UPPER_RESET;
         thresh_ff.lower <= LOWER_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   // Front: count bytes and gather the sample pairs
   gfu_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (byte_take),
      .data_byte   (req_data_byte),
      .frame_start (req_frame_start),
      .item_push   (front_push),
      .item        (front_item)
   );

   // Short queue between front and back
   gfu_fifo #(
      .WIDTH($bits(sample_item_type)),
      .DEPTH(ITEM_DEPTH)
   ) u_item_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .wr_data (front_item),
      .pop     (item_pop),
      .rd_data (queued_item),
      .full    (item_full),
      .empty   (item_empty),
      .count   (item_count)
   );

   // Back: window shift, offset tracking, result queue
   gfu_track u_track (
      .clock      (clock),
      .reset      (reset),
      .thresh     (thresh_ff),
      .item_empty (item_empty),
      .item       (queued_item),
      .item_pop   (item_pop),
      .rsp_item   (rsp_item),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop)
   );

   assign rsp_gaze_x      = rsp_item.gaze_x;
   assign rsp_gaze_y      = rsp_item.gaze_y;
   assign rsp_sample_slot = rsp_item.slot;

   // Occupancy of the pair queue is only needed for its full flag
   logic unused_count;
   assign unused_count = ^item_count;

endmodule

// ===== src/gfu_checker.sv =====
`include "gaze_frame_unpack_offset_tracker_core_assert.svh"

module gfu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_gaze_x,
   input logic [31:0] rsp_gaze_y,
   input logic        rsp_sample_slot
);

   // Reset leaves no stale word on the result side
   `GFU_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> rsp_empty)

   // Reset frees the input side
   `GFU_ASSERT_ALWAYS(a_reset_accepts, clock, reset |=> !req_full)

   // A waiting word stays until popped
   `GFU_ASSERT(a_word_holds, clock, reset, (!rsp_empty && !rsp_pop) |=> !rsp_empty)

   // A waiting word keeps its value until popped
   `GFU_ASSERT(a_word_stable, clock, reset,
      (!rsp_empty && !rsp_pop) |=> ($stable(rsp_gaze_x) && $stable(rsp_gaze_y)
         && $stable(rsp_sample_slot)))

endmodule

bind gaze_frame_unpack_offset_tracker_core gfu_checker u_gfu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_gaze_x      (rsp_gaze_x),
   .rsp_gaze_y      (rsp_gaze_y),
   .rsp_sample_slot (rsp_sample_slot)
);

// ===== tb/gaze_frame_unpack_offset_tracker_core_tb.sv =====
`timescale 1ns / 1ps

module gaze_frame_unpack_offset_tracker_core_tb;
   import gfu_pkg::*;

   localparam int unsigned FRAME_BYTES   = FRAME_BYTES_DEF;
   localparam int          PHASES        = 5;
   localparam int          PHASE_ITEMS   = 250;   // in-frame bytes per random phase
   localparam int          SETTLE_CYCLES = 10;    // extra idle after all words drain
   localparam int          LONG_HOLD     = 500;   // result side stall that backs up req_full
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          REPORT_MAX    = 10;

   typedef enum {
      SHAPE_SINGLE,  // frame cut right after the first pair
      SHAPE_FULL,    // both pairs, ends inside the frame
      SHAPE_LONG,    // runs past FRAME_BYTES, some past the position ceiling
      SHAPE_BROKEN,  // restart before the second pair completes
      SHAPE_NOISE    // bytes with no frame start, continue the old count
   } frame_shape_type;

   typedef struct {
      logic [7:0]      data;
      bit              start;
      bit              typed;   // word below is the expectation, not the predictor's
      result_item_type word;
   } stim_row_type;

   // DUT ports
   logic                        clock;
   logic                        reset;
   logic                        req_push;
   logic                        req_full;
   logic [7:0]                  req_data_byte;
   logic                        req_frame_start;
   logic                        rsp_empty;
   logic                        rsp_pop;
   logic signed [OUT_W-1:0]     rsp_gaze_x;
   logic signed [OUT_W-1:0]     rsp_gaze_y;
   logic                        rsp_sample_slot;
   logic                        csr_we;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [SAMPLE_W-1:0]         csr_wdata;

   // Tracker state as the testbench sees it
   logic [SAMPLE_W-1:0]         thr_upper;
   logic [SAMPLE_W-1:0]         thr_lower;
   win_type                     x_hist;
   win_type                     y_hist;
   logic signed [OUT_W-1:0]     x_bias;
   logic signed [OUT_W-1:0]     y_bias;
   logic [POS_W-1:0]            next_pos;
   logic [SAMPLE_W-1:0]         y_held;
   logic [3:0]                  x_nib;

   result_item_type             pending_gaze_words[$];
   int                          mismatch_count;
   int                          in_frame_bytes;
   int                          tx_gap_pct;
   int                          rx_gap_pct;
   bit                          hold_armed;
   bit                          hold_done;
   int                          upper_set[PHASES];
   int                          lower_set[PHASES];

   // Directed bytes. Typed words are the ones visible by inspection: windows still at
   // 2048 after reset, so the emitted entry is the reset level or the previous sample.
   stim_row_type directed_rows[20] = '{
      '{8'h12, 1'b0, 1'b0, '0},                          // byte before any frame start
      '{8'h34, 1'b0, 1'b0, '0},
      '{8'h56, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},                          // y = 0
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, '{32'sd2048, 32'sd2048, 1'b0}}, // x = 0, emits reset level
      '{8'hAA, 1'b1, 1'b0, '0},                          // first real frame start
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},                          // y = 4095
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, '{32'sd0, 32'sd0, 1'b0}},     // x = 4095, emits previous zero
      '{8'h5A, 1'b1, 1'b0, '0},                          // short frame
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'hC3, 1'b1, 1'b0, '0},                          // restart the count
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'hFE, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'h0F, 1'b0, 1'b0, '0},
      '{8'hF0, 1'b0, 1'b0, '0}                           // lower correction kicks in
   };

   gaze_frame_unpack_offset_tracker_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_byte   (req_data_byte),
      .req_frame_start (req_frame_start),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_gaze_x      (rsp_gaze_x),
      .rsp_gaze_y      (rsp_gaze_y),
      .rsp_sample_slot (rsp_sample_slot),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic signed [OUT_W-1:0] clamp32(input longint v);
      if (v > longint'(32'sh7FFF_FFFF)) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < -longint'(64'sh8000_0000)) begin
         return 32'sh8000_0000;
      end
      return v[OUT_W-1:0];
   endfunction

   // Shift one sample into an axis window, apply the wrap correction, return w2 + bias.
   task automatic advance_axis(inout win_type hist, inout logic signed [OUT_W-1:0] bias,
                               input logic [SAMPLE_W-1:0] s,
                               output logic signed [OUT_W-1:0] level);
      int d;
      hist = {s, hist[3], hist[2], hist[1]};
      // integer division truncates toward zero
      d = (int'(hist[0]) - 3 * int'(hist[1]) + 3 * int'(hist[2]) - int'(hist[3])) / 2;
      // upper test first: it wins when both thresholds are met
      if (hist[1] > thr_upper) begin
         bias = clamp32(longint'(bias) - longint'(d));
      end else if (hist[1] < thr_lower) begin
         bias = clamp32(longint'(bias) + longint'(d));
      end
      level = clamp32(longint'(hist[2]) + longint'(bias));
   endtask

   task automatic reset_tracker();
      thr_upper = UPPER_RESET;
      thr_lower = LOWER_RESET;
      x_hist    = {4{WIN_RESET}};
      y_hist    = {4{WIN_RESET}};
      x_bias    = '0;
      y_bias    = '0;
      next_pos  = '0;
      y_held    = '0;
      x_nib     = '0;
   endtask

   // Advance the byte count for one accepted byte and work out the word it completes.
   task automatic predict_gaze_word(input logic [7:0] b, input bit start,
                                    output bit produced, output result_item_type word,
                                    output bit in_frame);
      logic [POS_W-1:0] pos;
      pos      = start ? '0 : next_pos;
      next_pos = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
      produced = 1'b0;
      word     = '0;
      in_frame = (pos < FRAME_BYTES);
      if (!in_frame) begin
         return;
      end
      if (pos == POS_A_HI || pos == POS_B_HI) begin
         y_held = {b, 4'h0};
      end else if (pos == POS_A_MID || pos == POS_B_MID) begin
         y_held = {y_held[11:4], b[7:4]};
         x_nib  = b[3:0];
      end else if (pos == POS_A_LO || pos == POS_B_LO) begin
         advance_axis(x_hist, x_bias, {x_nib, b}, word.gaze_x);
         advance_axis(y_hist, y_bias, y_held, word.gaze_y);
         word.slot = (pos == POS_B_LO);
         produced  = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   // Offer one byte, hold it until taken, then log what it should produce.
   task automatic send_byte(input logic [7:0] b, input bit start, input bit typed,
                            input result_item_type typed_word);
      bit              produced;
      bit              in_frame;
      result_item_type word;
      if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_data_byte   <= b;
      req_frame_start <= start;
      do @(posedge clock); while (req_full);
      predict_gaze_word(b, start, produced, word, in_frame);
      if (produced) begin
         pending_gaze_words.push_back(typed ? typed_word : word);
      end
      if (in_frame) begin
         in_frame_bytes++;
      end
   endtask

   // Bias samples toward the rails and the thresholds so corrections fire often.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int v;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = 4095;
         2: v = int'(thr_upper) + int'($urandom_range(0, 4)) - 2;
         3: v = int'(thr_lower) + int'($urandom_range(0, 4)) - 2;
         4: v = $urandom_range(0, 300);
         5: v = $urandom_range(3795, 4095);
         default: v = $urandom_range(0, 4095);
      endcase
      if (v < 0) begin
         v = 0;
      end
      if (v > 4095) begin
         v = 4095;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic send_frame(input bit quiet);
      frame_shape_type     shape;
      int                  r;
      int                  len;
      logic [SAMPLE_W-1:0] xs;
      logic [SAMPLE_W-1:0] ys;
      logic [7:0]          b;
      r     = $urandom_range(0, 99);
      shape = (r < 35) ? SHAPE_SINGLE : (r < 65) ? SHAPE_FULL : (r < 75) ? SHAPE_LONG :
              (r < 88) ? SHAPE_BROKEN : SHAPE_NOISE;
      case (shape)
         SHAPE_SINGLE: len = 6;
         SHAPE_FULL:   len = $urandom_range(34, FRAME_BYTES);
         SHAPE_LONG:   len = $urandom_range(FRAME_BYTES + 1, 72);
         SHAPE_BROKEN: len = $urandom_range(0, 1) ? $urandom_range(1, 5) : $urandom_range(6, 33);
         default:      len = $urandom_range(1, 8);
      endcase
      // pick the idle mix per frame; some frames run without gaps at all
      if (quiet || $urandom_range(0, 2) == 0) begin
         tx_gap_pct = 0;
         rx_gap_pct = 0;
      end else begin
         tx_gap_pct = $urandom_range(0, 12);
         rx_gap_pct = $urandom_range(0, 12);
      end
      xs = '0;
      ys = '0;
      for (int p = 0; p < len; p++) begin
         if (p == POS_A_HI || p == POS_B_HI) begin
            xs = pick_sample();
            ys = pick_sample();
         end
         if (shape == SHAPE_NOISE) begin
            b = 8'($urandom_range(0, 255));
         end else if (p == POS_A_HI || p == POS_B_HI) begin
            b = ys[11:4];
         end else if (p == POS_A_MID || p == POS_B_MID) begin
            b = {ys[3:0], xs[11:8]};
         end else if (p == POS_A_LO || p == POS_B_LO) begin
            b = xs[7:0];
         end else begin
            b = 8'($urandom_range(0, 255));
         end
         send_byte(b, shape != SHAPE_NOISE && p == 0, 1'b0, '0);
      end
   endtask

   // Drop the push, let every word drain, then give in-flight bytes time to settle.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_gaze_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both thresholds back to back; write enable stays high across the pair.
   task automatic set_thresholds(input logic [SAMPLE_W-1:0] upper,
                                 input logic [SAMPLE_W-1:0] lower);
      csr_we    <= 1'b1;
      csr_index <= CSR_UPPER;
      csr_wdata <= upper;
      @(posedge clock);
      csr_index <= CSR_LOWER;
      csr_wdata <= lower;
      @(posedge clock);
      csr_we    <= 1'b0;
      thr_upper = upper;
      thr_lower = lower;
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin
      req_push        = 1'b0;
      req_data_byte   = '0;
      req_frame_start = 1'b0;
      csr_we          = 1'b0;
      csr_index       = CSR_UPPER;
      csr_wdata       = '0;
      reset           = 1'b1;
      mismatch_count  = 0;
      in_frame_bytes  = 0;
      tx_gap_pct      = 0;
      rx_gap_pct      = 0;
      hold_armed      = 1'b0;
      hold_done       = 1'b0;
      reset_tracker();

      // threshold settings per phase: defaults, both rails, swapped rails, two random
      upper_set = '{3939, 4095, 0, $urandom_range(0, 4095), $urandom_range(1800, 4095)};
      lower_set = '{256, 0, 4095, $urandom_range(0, 4095), $urandom_range(0, 2300)};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed bytes run against the reset thresholds
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].data, directed_rows[i].start, directed_rows[i].typed,
                   directed_rows[i].word);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         set_thresholds(SAMPLE_W'(upper_set[ph]), SAMPLE_W'(lower_set[ph]));
         // stall the result side once, early, while bytes keep coming
         if (ph == 1) begin
            hold_armed = 1'b1;
         end
         in_frame_bytes = 0;
         while (in_frame_bytes < PHASE_ITEMS) begin
            send_frame(ph == PHASES - 1);
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------- result side

   // Pop continuously, with random idle bursts and one long hold-off.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
      end
   end

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("%0t: mismatch: %s", $realtime, msg);
      end
   endtask

   // Compare every popped word against the oldest expectation, field by field.
   always @(posedge clock) begin
      result_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_gaze_words.size() == 0) begin
            flag_mismatch($sformatf("unexpected word x=%0d y=%0d slot=%0d",
                                    rsp_gaze_x, rsp_gaze_y, rsp_sample_slot));
         end else begin
            want = pending_gaze_words.pop_front();
            if (rsp_gaze_x !== want.gaze_x) begin
               flag_mismatch($sformatf("gaze_x expected %0d, got %0d",
                                       want.gaze_x, rsp_gaze_x));
            end
            if (rsp_gaze_y !== want.gaze_y) begin
               flag_mismatch($sformatf("gaze_y expected %0d, got %0d",
                                       want.gaze_y, rsp_gaze_y));
            end
            if (rsp_sample_slot !== want.slot) begin
               flag_mismatch($sformatf("sample_slot expected %0d, got %0d",
                                       want.slot, rsp_sample_slot));
            end
         end
      end
   end

   // Watchdog: count cycles and give up well past the slowest legal run.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
